// ===== hdl/spa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types, command codes and saturating arithmetic for the sparse
// polynomial accumulator.
// ----------------------------------------------------------------------------
package spa_pkg;

	localparam int CMD_W  = 2;
	localparam int EXP_W  = 10;
	localparam int COEF_W = 32;
	localparam int CNT_W  = 11;

	// Command codes carried in the input tuser
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// One result request
	typedef struct packed {
		logic [CNT_W-1:0]         nonzero_count;
		logic                     term_valid;
		logic [EXP_W-1:0]         term_exponent;
		logic signed [COEF_W-1:0] term_coefficient;
		logic                     last_term;
	} res_t;

	// Q16.16 add, clamped to the signed 32-bit range
	function automatic logic signed [COEF_W-1:0] sat_add(
		input logic signed [COEF_W-1:0] a,
		input logic signed [COEF_W-1:0] b
	);
		logic signed [COEF_W:0] s;
		logic signed [COEF_W-1:0] r;
		s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
		if (s[COEF_W] != s[COEF_W-1]) begin
			r = s[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
		end else begin
			r = s[COEF_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/spa_out_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spa_out_buf
// Two-entry result buffer: an output register plus a skid entry, so a result
// can be pushed while the previous one still waits on the master side.
// ----------------------------------------------------------------------------
module spa_out_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire spa_pkg::res_t res,
	output logic               room,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// [10:0] nonzero_count, [11] term_valid, [21:12] term_exponent,
	// [53:22] term_coefficient, [55:54] zero
	output logic [55:0]        m_tdata,
	output logic               m_tlast
);

	spa_pkg::res_t main_q;
	spa_pkg::res_t skid_q;
	logic          main_v_q;
	logic          skid_v_q;
	logic          pop;

	assign pop  = main_v_q && m_tready;
	assign room = !skid_v_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= push;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			if (!main_v_q) begin
				main_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// Payload: advance skid into main on a pop, else fill the free entry
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				main_q <= skid_q;
				if (push) begin
					skid_q <= res;
				end
			end else if (push) begin
				main_q <= res;
			end
		end else if (push) begin
			if (!main_v_q) begin
				main_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign m_tvalid = main_v_q;
	assign m_tdata  = {2'b00, main_q.term_coefficient, main_q.term_exponent,
		main_q.term_valid, main_q.nonzero_count};
	assign m_tlast  = main_q.last_term;

endmodule
`default_nettype wire

// ===== hdl/sparse_polynomial_accumulator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_polynomial_accumulator
// Coefficient table indexed by exponent with saturating Q16.16 term adds,
// descending reads of nonzero terms and table clear.
// ----------------------------------------------------------------------------
//  channel  dir  tuser          tdata                          tlast
//  s_*      in   command[1:0]   exponent, coefficient          -
//  m_*      out  -              count, valid, exponent, coeff  last_term
//
// Add: table read on accept, then saturate and write back in the next cycle.
// Read: the entries below the cursor are scanned downward, one table read
// per cycle, up to the next nonzero term after the one returned.
// Clear: the table is zeroed one entry per cycle.
// After reset the same zeroing pass runs with s_tready low. One request is
// worked at a time; a stalled master holds the next request off once both
// output entries are full.
// ----------------------------------------------------------------------------
module sparse_polynomial_accumulator #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [9:0] exponent, [41:10] coefficient, [47:42] zero
	input  wire logic [47:0] s_tdata,
	// [1:0] command
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [10:0] nonzero_count, [11] term_valid, [21:12] term_exponent,
	// [53:22] term_coefficient, [55:54] zero
	output logic [55:0]      m_tdata,
	output logic             m_tlast
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] TOP  = CW'(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

	localparam logic [2:0] ST_SWEEP = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_ADD   = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	// Coefficient table; zero means empty
	logic signed [spa_pkg::COEF_W-1:0] mem_q [TABLE_DEPTH];
	logic signed [spa_pkg::COEF_W-1:0] rd_data_q;
	logic                              rd_en;
	logic [AW-1:0]                     rd_addr;
	logic                              wr_en;
	logic [AW-1:0]                     wr_addr;
	logic signed [spa_pkg::COEF_W-1:0] wr_data;

	logic [2:0]                        state_q;
	logic [AW-1:0]                     sweep_q;
	logic                              sweep_rsp_q;
	logic [spa_pkg::CMD_W-1:0]         cmd_q;
	logic [AW-1:0]                     exp_q;
	logic signed [spa_pkg::COEF_W-1:0] coef_q;
	logic [spa_pkg::CNT_W-1:0]         count_q;
	logic [CW-1:0]                     cursor_q;
	logic [AW-1:0]                     issue_q;
	logic                              issue_more_q;
	logic                              flight_q;
	logic [AW-1:0]                     flight_idx_q;
	logic                              found_q;
	logic [AW-1:0]                     term_idx_q;
	logic signed [spa_pkg::COEF_W-1:0] term_coef_q;

	logic                              accept;
	logic [spa_pkg::CMD_W-1:0]         in_cmd;
	logic [spa_pkg::EXP_W-1:0]         in_exp;
	logic signed [spa_pkg::COEF_W-1:0] in_coef;
	logic [AW-1:0]                     in_idx;
	logic                              in_exp_ok;
	logic                              room;

	logic signed [spa_pkg::COEF_W-1:0] sum;
	logic [spa_pkg::CNT_W-1:0]         count_add;
	logic                              nz;
	logic                              scan_done;
	logic                              scan_found;
	logic                              scan_more;
	logic [AW-1:0]                     scan_idx;
	logic signed [spa_pkg::COEF_W-1:0] scan_coef;
	logic                              fin;
	spa_pkg::res_t                     res_c;

	assign in_cmd    = s_tuser;
	assign in_exp    = s_tdata[9:0];
	assign in_coef   = s_tdata[41:10];
	assign in_idx    = AW'(in_exp);
	assign in_exp_ok = 32'(in_exp) < 32'(TABLE_DEPTH);

	assign s_tready = (state_q == ST_IDLE) && room;
	assign accept   = s_tvalid && s_tready;

	// Table access
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Read port: add lookup on accept, one scan address per cycle
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = issue_q;
		if (accept && (in_cmd == spa_pkg::CMD_ADD) && in_exp_ok) begin
			rd_en   = 1'b1;
			rd_addr = in_idx;
		end else if ((state_q == ST_SCAN) && issue_more_q) begin
			rd_en = 1'b1;
		end
	end

	// Write port: zeroing sweep or add write-back
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = sweep_q;
		wr_data = '0;
		if (state_q == ST_SWEEP) begin
			wr_en = 1'b1;
		end else if (state_q == ST_ADD) begin
			wr_en   = 1'b1;
			wr_addr = exp_q;
			wr_data = sum;
		end
	end

	// Saturating add and nonzero count adjust
	always_comb begin
		sum       = spa_pkg::sat_add(rd_data_q, coef_q);
		count_add = count_q;
		if ((rd_data_q != '0) && (sum == '0)) begin
			count_add = count_q - 1'b1;
		end else if ((rd_data_q == '0) && (sum != '0)) begin
			count_add = count_q + 1'b1;
		end
	end

	// Scan evaluation of the entry whose data just returned
	always_comb begin
		nz         = flight_q && (rd_data_q != '0);
		scan_done  = flight_q && ((found_q && nz) || (flight_idx_q == '0));
		scan_found = found_q || nz;
		scan_more  = found_q && nz;
		scan_idx   = found_q ? term_idx_q : flight_idx_q;
		scan_coef  = found_q ? term_coef_q : rd_data_q;
	end

	// Result build
	always_comb begin
		fin   = 1'b0;
		res_c = '0;
		res_c.nonzero_count = count_q;
		case (state_q)
			ST_ADD: begin
				fin = 1'b1;
				res_c.nonzero_count = count_add;
			end
			ST_SCAN: begin
				fin = scan_done;
				if (scan_found) begin
					res_c.term_valid       = 1'b1;
					res_c.term_exponent    = spa_pkg::EXP_W'(scan_idx);
					res_c.term_coefficient = scan_coef;
					res_c.last_term        = !scan_more;
				end else begin
					res_c.last_term = 1'b1;
				end
			end
			ST_SWEEP: begin
				fin = sweep_rsp_q && (sweep_q == LAST);
			end
			ST_FIN: begin
				fin = 1'b1;
				res_c.last_term = (cmd_q == spa_pkg::CMD_READ);
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// Request latch and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_q      <= '0;
			sweep_rsp_q  <= 1'b0;
			count_q      <= '0;
			cursor_q     <= TOP;
			issue_more_q <= 1'b0;
			flight_q     <= 1'b0;
			found_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					if (sweep_q == LAST) begin
						sweep_q     <= '0;
						sweep_rsp_q <= 1'b0;
						state_q     <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (in_cmd)
							spa_pkg::CMD_ADD: begin
								state_q <= in_exp_ok ? ST_ADD : ST_FIN;
							end
							spa_pkg::CMD_READ: begin
								if (cursor_q == '0) begin
									state_q <= ST_FIN;
								end else begin
									state_q      <= ST_SCAN;
									issue_q      <= AW'(cursor_q - 1'b1);
									issue_more_q <= 1'b1;
									flight_q     <= 1'b0;
									found_q      <= 1'b0;
								end
							end
							spa_pkg::CMD_CLEAR: begin
								state_q     <= ST_SWEEP;
								sweep_q     <= '0;
								sweep_rsp_q <= 1'b1;
								count_q     <= '0;
								cursor_q    <= TOP;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_ADD: begin
					count_q <= count_add;
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (nz && !found_q) begin
						found_q     <= 1'b1;
						term_idx_q  <= flight_idx_q;
						term_coef_q <= rd_data_q;
					end
					if (scan_done) begin
						state_q      <= ST_IDLE;
						issue_more_q <= 1'b0;
						flight_q     <= 1'b0;
						cursor_q     <= scan_found ? CW'(scan_idx) : TOP;
					end else begin
						// advance the issue pointer, track the returning entry
						flight_q     <= issue_more_q;
						flight_idx_q <= issue_q;
						if (issue_more_q) begin
							if (issue_q == '0) begin
								issue_more_q <= 1'b0;
							end else begin
								issue_q <= issue_q - 1'b1;
							end
						end
					end
				end
				ST_FIN: begin
					if (cmd_q == spa_pkg::CMD_READ) begin
						cursor_q <= TOP;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= in_cmd;
			exp_q  <= in_idx;
			coef_q <= in_coef;
		end
	end

	spa_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fin),
		.res      (res_c),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire
